/* design/tlprq_pkg.sv */
// ----------------------------------------------------------------------------
// tlprq_pkg
// Shared types, sizes and helpers for the three-level priority ring queue.
// ----------------------------------------------------------------------------
package tlprq_pkg;

    localparam int DEPTH       = 8;
    localparam int LEVELS      = 3;
    localparam int LVL_W       = 2;
    localparam int CODE_W      = 8;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int STORE_DEPTH = LEVELS * DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req_kind;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic fill;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic pop_hit;
    } t_dp_status;

    function automatic logic [PTR_W-1:0] ptr_wrap(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [PTR_W-1:0] ptr);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(ADDR_W'(lvl) * ADDR_W'(DEPTH)) + ADDR_W'(ptr);
        return a;
    endfunction

endpackage

/* design/tlprq_ram.sv */
// ----------------------------------------------------------------------------
// tlprq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/tlprq_datapath.sv */
// ----------------------------------------------------------------------------
// tlprq_datapath
// Ring pointers, entry store, idle code register and result register.
// ----------------------------------------------------------------------------
module tlprq_datapath
    import tlprq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  t_req_kind         i_req_kind,
    input  logic [LVL_W-1:0]  i_lvl,
    input  logic [CODE_W-1:0] i_entry,
    input  logic              i_cfg_we,
    input  logic [CODE_W-1:0] i_cfg_data,
    output logic [CODE_W-1:0] o_entry,
    output logic              o_got,
    output logic              o_drop
);

    logic [PTR_W-1:0]  r_rd_ptr [LEVELS];
    logic [PTR_W-1:0]  r_wr_ptr [LEVELS];
    logic [PTR_W-1:0]  n_rd_ptr [LEVELS];
    logic [PTR_W-1:0]  n_wr_ptr [LEVELS];
    logic [CODE_W-1:0] r_idle_code;
    logic [CODE_W-1:0] r_entry;
    logic              r_got;
    logic              r_drop;
    logic [CODE_W-1:0] n_entry;
    logic              n_got;
    logic              n_drop;

    logic              is_push;
    logic              lvl_ok;
    logic [LVL_W-1:0]  lvl_idx;
    logic [PTR_W-1:0]  wp;
    logic [PTR_W-1:0]  wp_next;
    logic              push_drop;
    logic [LEVELS-1:0] busy;
    logic              found;
    logic [LVL_W-1:0]  hit_lvl;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CODE_W-1:0] ram_rdata;

    always_comb begin
        is_push   = (i_req_kind == REQ_PUSH);
        lvl_ok    = (i_lvl < LVL_W'(LEVELS));
        lvl_idx   = lvl_ok ? i_lvl : '0;
        wp        = r_wr_ptr[lvl_idx];
        wp_next   = ptr_wrap(wp);
        push_drop = lvl_ok && (r_rd_ptr[lvl_idx] == wp_next);

        // highest non-empty level wins
        hit_lvl = '0;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            busy[k] = (r_rd_ptr[k] != r_wr_ptr[k]);
            if (busy[k]) begin
                hit_lvl = LVL_W'(k);
            end
        end
        found = |busy;

        o_status.pop_hit = !is_push && found;

        ram_we    = i_cmd.take && is_push && lvl_ok;
        ram_waddr = slot_addr(lvl_idx, wp);
        ram_raddr = slot_addr(hit_lvl, r_rd_ptr[hit_lvl]);

        for (int k = 0; k < LEVELS; k++) begin
            n_rd_ptr[k] = r_rd_ptr[k];
            n_wr_ptr[k] = r_wr_ptr[k];
            if (ram_we && (lvl_idx == LVL_W'(k))) begin
                n_wr_ptr[k] = wp_next;
                if (push_drop) begin
                    n_rd_ptr[k] = ptr_wrap(r_rd_ptr[k]);
                end
            end
            if (i_cmd.take && !is_push && found && (hit_lvl == LVL_W'(k))) begin
                n_rd_ptr[k] = ptr_wrap(r_rd_ptr[k]);
            end
        end

        n_entry = r_entry;
        n_got   = r_got;
        n_drop  = r_drop;
        if (i_cmd.take) begin
            if (is_push) begin
                n_entry = '0;
                n_got   = 1'b0;
                n_drop  = push_drop;
            end else begin
                // a pop that hits finishes on fill
                n_entry = r_idle_code;
                n_got   = 1'b0;
                n_drop  = 1'b0;
            end
        end else if (i_cmd.fill) begin
            n_entry = ram_rdata;
            n_got   = 1'b1;
            n_drop  = 1'b0;
        end
    end

    tlprq_ram #(
        .WIDTH (CODE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_entry),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LEVELS; k++) begin
                r_rd_ptr[k] <= '0;
                r_wr_ptr[k] <= '0;
            end
            r_idle_code <= '0;
        end else begin
            for (int k = 0; k < LEVELS; k++) begin
                r_rd_ptr[k] <= n_rd_ptr[k];
                r_wr_ptr[k] <= n_wr_ptr[k];
            end
            if (i_cfg_we) begin
                r_idle_code <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_got   <= n_got;
        r_drop  <= n_drop;
    end

    assign o_entry = r_entry;
    assign o_got   = r_got;
    assign o_drop  = r_drop;

    // pointers stay inside the ring
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_ptr[0] <= PTR_W'(DEPTH - 1)) && (r_wr_ptr[0] <= PTR_W'(DEPTH - 1)) &&
        (r_rd_ptr[1] <= PTR_W'(DEPTH - 1)) && (r_wr_ptr[1] <= PTR_W'(DEPTH - 1)) &&
        (r_rd_ptr[2] <= PTR_W'(DEPTH - 1)) && (r_wr_ptr[2] <= PTR_W'(DEPTH - 1)))
        else $error("ring pointer out of range");

    // a push to the high level never leaves it empty
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take && is_push && (i_lvl == '0)) |=> (r_rd_ptr[0] != r_wr_ptr[0]))
        else $error("push left high level empty");

endmodule

/* design/tlprq_ctrl.sv */
// ----------------------------------------------------------------------------
// tlprq_ctrl
// Handshake and sequencing: takes a beat, waits out the store read on a pop hit,
// and holds the result until the sink takes it.
// ----------------------------------------------------------------------------
module tlprq_ctrl
    import tlprq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        out_free    = !r_out_valid || i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd.take  = 1'b0;
        o_cmd.fill  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = out_free;
                o_cmd.take = i_in_valid && out_free;
                if (o_cmd.take) begin
                    if (i_status.pop_hit) begin
                        n_state = S_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_READ: begin
                // store data is valid now
                o_cmd.fill  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_hit_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_status.pop_hit) |=> (r_state == S_READ))
        else $error("pop hit did not enter read");

    // the result slot is empty while a store read is in flight
    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("result slot busy during read");

    a_fill_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fill |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("fill did not present a result");

endmodule

/* design/three_level_priority_ring_queue.sv */
// ----------------------------------------------------------------------------
// three_level_priority_ring_queue
// Three ring queues of entry codes (high, medium, low) with push and pop.
// ----------------------------------------------------------------------------
//  channel   dir  ports                       beat contents
//  s_axis    in   tvalid tready tdata tuser   push/pop request
//  m_axis    out  tvalid tready tdata tuser   one result per request
//  cfg       in   i_cfg_valid o_cfg_ready     idle code write
//
//  a push or a pop on empty levels shows its result in the cycle after the beat
//  is taken; a pop that finds an entry first waits in the read state for the
//  registered read of the entry store; one request is in work at a time.
//  reset is synchronous and active low, clears all pointers and the idle code.
//  a held result stalls new requests only until the sink takes it.
//  the config channel is always ready.
// ----------------------------------------------------------------------------
module three_level_priority_ring_queue
    import tlprq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // priority_req[1:0], entry_in[9:2], zero pad
    input  logic [S_TUSER_W-1:0] s_axis_tuser,   // req_type[0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // entry_out[7:0]
    output logic [M_TUSER_W-1:0] m_axis_tuser,   // got_entry[0], dropped_oldest[1]
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CODE_W-1:0]    i_cfg_data
);

    t_dp_cmd     cmd;
    t_dp_status  status;
    logic        got;
    logic        drop;

    tlprq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    tlprq_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_req_kind (t_req_kind'(s_axis_tuser[0])),
        .i_lvl      (s_axis_tdata[LVL_W-1:0]),
        .i_entry    (s_axis_tdata[LVL_W+CODE_W-1:LVL_W]),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_entry    (m_axis_tdata),
        .o_got      (got),
        .o_drop     (drop)
    );

    assign m_axis_tuser = {drop, got};
    assign o_cfg_ready  = 1'b1;

endmodule
